// ----- sv/ssm_pkg.sv -----
`default_nettype none

package ssm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int VALUE_W = 32;

  localparam logic [1:0] OP_PUSH_A = 2'd0;
  localparam logic [1:0] OP_PUSH_B = 2'd1;
  localparam logic [1:0] OP_MERGE = 2'd2;

  localparam logic [1:0] STATUS_SUCCESS = 2'd0;
  localparam logic [1:0] STATUS_UNSORTED = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

endpackage

`default_nettype wire

// ----- sv/ssm_store.sv -----
`default_nettype none

module ssm_store #(
  parameter int DEPTH = ssm_pkg::LIST_DEPTH,
  parameter int ADDR_W = 5,
  parameter int DATA_W = ssm_pkg::VALUE_W
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [ADDR_W-1:0] waddr,
  input wire logic [DATA_W-1:0] wdata,
  input wire logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/sorted_sequence_merge.sv -----
// Channel   Ports                              Transfer
// command   start, busy, operation, value      start high while busy is low
// result    strobe, status, value_res, last    strobe high, one cycle each
//
// A push leaves busy low, so pushes can follow back to back.
// A merge that fails a check gives its single result in the next cycle.
// A successful merge keeps busy high while it walks both stores and gives one
// result per cycle, paced by the registered read port of each store.
// Reset is synchronous and empties both stores; the receiver cannot stall.
`default_nettype none

module sorted_sequence_merge #(
  parameter int LIST_DEPTH = ssm_pkg::LIST_DEPTH
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire logic [1:0] operation,
  input wire logic signed [ssm_pkg::VALUE_W-1:0] value,
  output logic strobe,
  output logic [1:0] status,
  output logic signed [ssm_pkg::VALUE_W-1:0] value_res,
  output logic last
);

  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic sorted_a;
  logic sorted_b;
  logic overflowed;
  logic signed [ssm_pkg::VALUE_W-1:0] tail_a;
  logic signed [ssm_pkg::VALUE_W-1:0] tail_b;
  logic [CNT_W-1:0] ia;
  logic [CNT_W-1:0] ib;
  logic [CNT_W-1:0] ia_next;
  logic [CNT_W-1:0] ib_next;
  logic [ssm_pkg::VALUE_W-1:0] rdata_a;
  logic [ssm_pkg::VALUE_W-1:0] rdata_b;

  logic accept;
  logic push_a;
  logic push_b;
  logic merge_cmd;
  logic merge_err;
  logic [1:0] err_status;
  logic take_a;
  logic done;
  logic clear;
  logic we_a;
  logic we_b;
  logic [CNT_W:0] total;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign push_a = accept && (operation == ssm_pkg::OP_PUSH_A);
  assign push_b = accept && (operation == ssm_pkg::OP_PUSH_B);
  assign merge_cmd = accept && (operation == ssm_pkg::OP_MERGE);
  assign we_a = push_a && (count_a != DEPTH_C);
  assign we_b = push_b && (count_b != DEPTH_C);
  assign total = {1'b0, count_a} + {1'b0, count_b};

  always_comb begin
    merge_err = 1'b1;
    if (overflowed) begin
      err_status = ssm_pkg::STATUS_OVERFLOW;
    end else if ((count_a == '0) || (count_b == '0)) begin
      err_status = ssm_pkg::STATUS_EMPTY;
    end else if (!sorted_a || !sorted_b) begin
      err_status = ssm_pkg::STATUS_UNSORTED;
    end else begin
      err_status = ssm_pkg::STATUS_SUCCESS;
      merge_err = 1'b0;
    end
  end

  always_comb begin
    take_a = (ia < count_a) &&
             ((ib >= count_b) || ($signed(rdata_a) < $signed(rdata_b)));
    done = (({1'b0, ia} + {1'b0, ib} + (CNT_W + 1)'(1)) == total);
    ia_next = '0;
    ib_next = '0;
    if (state == ST_MERGE && !done) begin
      ia_next = take_a ? ia + CNT_W'(1) : ia;
      ib_next = take_a ? ib : ib + CNT_W'(1);
    end
    clear = (merge_cmd && merge_err) || ((state == ST_MERGE) && done);
  end

  ssm_store #(
    .DEPTH(LIST_DEPTH),
    .ADDR_W(ADDR_W),
    .DATA_W(ssm_pkg::VALUE_W)
  ) u_store_a (
    .clk(clk),
    .we(we_a),
    .waddr(count_a[ADDR_W-1:0]),
    .wdata(value),
    .raddr(ia_next[ADDR_W-1:0]),
    .rdata(rdata_a)
  );

  ssm_store #(
    .DEPTH(LIST_DEPTH),
    .ADDR_W(ADDR_W),
    .DATA_W(ssm_pkg::VALUE_W)
  ) u_store_b (
    .clk(clk),
    .we(we_b),
    .waddr(count_b[ADDR_W-1:0]),
    .wdata(value),
    .raddr(ib_next[ADDR_W-1:0]),
    .rdata(rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count_a <= '0;
      count_b <= '0;
      sorted_a <= 1'b1;
      sorted_b <= 1'b1;
      overflowed <= 1'b0;
      ia <= '0;
      ib <= '0;
      strobe <= 1'b0;
    end else begin
      ia <= ia_next;
      ib <= ib_next;
      strobe <= (merge_cmd && merge_err) || (state == ST_MERGE);
      if (push_a) begin
        if (count_a == DEPTH_C) begin
          overflowed <= 1'b1;
        end else begin
          if ((count_a != '0) && (value < tail_a)) begin
            sorted_a <= 1'b0;
          end
          count_a <= count_a + CNT_W'(1);
        end
      end
      if (push_b) begin
        if (count_b == DEPTH_C) begin
          overflowed <= 1'b1;
        end else begin
          if ((count_b != '0) && (value < tail_b)) begin
            sorted_b <= 1'b0;
          end
          count_b <= count_b + CNT_W'(1);
        end
      end
      if (merge_cmd && !merge_err) begin
        state <= ST_MERGE;
      end
      if (clear) begin
        state <= ST_IDLE;
        count_a <= '0;
        count_b <= '0;
        sorted_a <= 1'b1;
        sorted_b <= 1'b1;
        overflowed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      tail_a <= value;
    end
    if (we_b) begin
      tail_b <= value;
    end
    if (state == ST_MERGE) begin
      status <= ssm_pkg::STATUS_SUCCESS;
      value_res <= take_a ? $signed(rdata_a) : $signed(rdata_b);
      last <= done;
    end else begin
      status <= err_status;
      value_res <= '0;
      last <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ssm_checker.sv -----
`default_nettype none

module ssm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic [1:0] operation,
  input wire logic strobe,
  input wire logic [1:0] status,
  input wire logic [ssm_pkg::VALUE_W-1:0] value_res,
  input wire logic last
);

  // A failed merge gives exactly one result, and it is the last one.
  assert property (@(posedge clk) disable iff (rst)
    strobe && (status != ssm_pkg::STATUS_SUCCESS) |-> last && (value_res == '0))
    else $error("error result not marked last or carries a value");

  // The results of one merge come in consecutive cycles.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && (status == ssm_pkg::STATUS_SUCCESS))
    else $error("gap or status change inside a merge");

  // A merge transfer either gives its error result or starts the walk.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && (operation == ssm_pkg::OP_MERGE) |=> busy || (strobe && last))
    else $error("merge transfer had no visible effect");

  // A push never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && (operation != ssm_pkg::OP_MERGE) |=> !strobe)
    else $error("result after a push");

endmodule

bind sorted_sequence_merge ssm_checker u_ssm_checker (.*);

`default_nettype wire

// ----- test/tb_sorted_sequence_merge.sv -----
`timescale 1ns / 100ps

module tb_sorted_sequence_merge;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2 * ssm_pkg::LIST_DEPTH + 20;
  localparam int RANDOM_ITEMS = 160;
  localparam int RUN_MAX = ssm_pkg::LIST_DEPTH + 4;

  typedef struct packed {
    logic [1:0] op;
    logic signed [ssm_pkg::VALUE_W-1:0] val;
  } command_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [ssm_pkg::VALUE_W-1:0] value;
    logic last;
  } merge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] operation = ssm_pkg::OP_PUSH_A;
  logic signed [ssm_pkg::VALUE_W-1:0] value = '0;
  logic busy;
  logic strobe;
  logic [1:0] status;
  logic signed [ssm_pkg::VALUE_W-1:0] value_res;
  logic last;

  command_t pending_cmds[$];
  merge_result_t expected_results[$];
  command_t cmd_in_flight;

  logic signed [ssm_pkg::VALUE_W-1:0] stored_vals[2][ssm_pkg::LIST_DEPTH];
  int stored_count[2];
  bit in_order[2];
  bit dropped_push;

  logic signed [ssm_pkg::VALUE_W-1:0] run_vals[2][RUN_MAX];

  int fail_count = 0;
  int cycle_count = 0;
  int cmds_accepted = 0;
  int merges_done = 0;
  int results_checked = 0;
  int outcome_count[4];
  int idle_left = 0;
  bit no_idle = 1'b0;
  bit next_start;
  int stim_items = 0;

  sorted_sequence_merge #(
    .LIST_DEPTH(ssm_pkg::LIST_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .value(value),
    .strobe(strobe),
    .status(status),
    .value_res(value_res),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic add_expected(input logic [1:0] st,
                              input logic signed [ssm_pkg::VALUE_W-1:0] v,
                              input logic lst);
    merge_result_t r;
    r.status = st;
    r.value = v;
    r.last = lst;
    expected_results.push_back(r);
    if (lst) outcome_count[st]++;
  endtask

  task automatic apply_command(input command_t c);
    int side;
    int ia;
    int ib;
    int total;
    int n;
    logic signed [ssm_pkg::VALUE_W-1:0] v;
    logic signed [ssm_pkg::VALUE_W-1:0] pick;
    side = c.op[0];
    v = c.val;
    case (c.op)
      ssm_pkg::OP_PUSH_A, ssm_pkg::OP_PUSH_B: begin
        if (stored_count[side] >= ssm_pkg::LIST_DEPTH) begin
          dropped_push = 1'b1;
        end else begin
          if (stored_count[side] > 0 && v < stored_vals[side][stored_count[side] - 1]) begin
            in_order[side] = 1'b0;
          end
          stored_vals[side][stored_count[side]] = v;
          stored_count[side]++;
        end
      end
      ssm_pkg::OP_MERGE: begin
        merges_done++;
        if (dropped_push) begin
          add_expected(ssm_pkg::STATUS_OVERFLOW, '0, 1'b1);
        end else if (stored_count[0] == 0 || stored_count[1] == 0) begin
          add_expected(ssm_pkg::STATUS_EMPTY, '0, 1'b1);
        end else if (!in_order[0] || !in_order[1]) begin
          add_expected(ssm_pkg::STATUS_UNSORTED, '0, 1'b1);
        end else begin
          ia = 0;
          ib = 0;
          n = 0;
          total = stored_count[0] + stored_count[1];
          while (ia < stored_count[0] || ib < stored_count[1]) begin
            if (ia < stored_count[0] &&
                (ib >= stored_count[1] || stored_vals[0][ia] < stored_vals[1][ib])) begin
              pick = stored_vals[0][ia];
              ia++;
            end else begin
              pick = stored_vals[1][ib];
              ib++;
            end
            n++;
            add_expected(ssm_pkg::STATUS_SUCCESS, pick, n == total);
          end
        end
        stored_count[0] = 0;
        stored_count[1] = 0;
        in_order[0] = 1'b1;
        in_order[1] = 1'b1;
        dropped_push = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [ssm_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_command(input logic [1:0] op,
                             input logic signed [ssm_pkg::VALUE_W-1:0] v);
    command_t c;
    c.op = op;
    c.val = v;
    pending_cmds.push_back(c);
    if (op != OP_UNUSED) stim_items++;
  endtask

  task automatic fill_run(input int side, input int n, input bit ordered);
    logic signed [ssm_pkg::VALUE_W-1:0] tmp;
    for (int i = 0; i < n; i++) run_vals[side][i] = pick_value();
    if (ordered) begin
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j + 1 < n - i; j++) begin
          if (run_vals[side][j + 1] < run_vals[side][j]) begin
            tmp = run_vals[side][j];
            run_vals[side][j] = run_vals[side][j + 1];
            run_vals[side][j + 1] = tmp;
          end
        end
      end
    end
  endtask

  task automatic add_sequence(input int na, input int nb, input bit ordered);
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    fill_run(0, na, ordered || $urandom_range(0, 1) == 0);
    fill_run(1, nb, ordered);
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 11) == 0) add_command(OP_UNUSED, $urandom);
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 0)) begin
        add_command(ssm_pkg::OP_PUSH_A, run_vals[0][ia]);
        ia++;
      end else begin
        add_command(ssm_pkg::OP_PUSH_B, run_vals[1][ib]);
        ib++;
      end
    end
    add_command(ssm_pkg::OP_MERGE, $urandom);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        apply_command(cmd_in_flight);
        cmds_accepted++;
        if (cmds_accepted % 32 == 0) no_idle = $urandom_range(0, 2) == 0;
        idle_left = pick_idle();
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_cmds.size() > 0) begin
          cmd_in_flight = pending_cmds.pop_front();
          operation <= cmd_in_flight.op;
          value <= cmd_in_flight.val;
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  always @(posedge clk) begin
    merge_result_t r;
    if (!rst && strobe === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: status %0d value_res %0d last %0d",
               status, value_res, last);
        fail_count++;
      end else begin
        r = expected_results.pop_front();
        results_checked++;
        if (status !== r.status) begin
          $error("status: expected %0d, actual %0d", r.status, status);
          fail_count++;
        end
        if (value_res !== r.value) begin
          $error("value_res: expected %0d, actual %0d", r.value, value_res);
          fail_count++;
        end
        if (last !== r.last) begin
          $error("last: expected %0d, actual %0d", r.last, last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sorted_sequence_merge failed");
      $finish;
    end
  end

  initial begin
    int na;
    int nb;
    int r;
    stored_count[0] = 0;
    stored_count[1] = 0;
    in_order[0] = 1'b1;
    in_order[1] = 1'b1;
    dropped_push = 1'b0;
    for (int i = 0; i < 4; i++) outcome_count[i] = 0;

    add_command(ssm_pkg::OP_MERGE, 32'sh7fff_ffff);
    add_command(ssm_pkg::OP_PUSH_A, 32'sh7fff_ffff);
    add_command(ssm_pkg::OP_MERGE, '0);
    add_command(ssm_pkg::OP_PUSH_B, 32'sh8000_0000);
    add_command(ssm_pkg::OP_MERGE, '0);
    add_command(ssm_pkg::OP_PUSH_A, 32'sh8000_0000);
    add_command(ssm_pkg::OP_PUSH_A, 32'sh7fff_ffff);
    add_command(ssm_pkg::OP_PUSH_B, 32'sh8000_0000);
    add_command(ssm_pkg::OP_PUSH_B, 32'sh7fff_ffff);
    add_command(ssm_pkg::OP_MERGE, '1);
    add_command(ssm_pkg::OP_PUSH_A, 5);
    add_command(ssm_pkg::OP_PUSH_A, 3);
    add_command(ssm_pkg::OP_PUSH_B, 0);
    add_command(ssm_pkg::OP_MERGE, '0);
    add_command(ssm_pkg::OP_PUSH_B, 2);
    add_command(ssm_pkg::OP_PUSH_B, 1);
    add_command(ssm_pkg::OP_PUSH_A, 0);
    add_command(ssm_pkg::OP_MERGE, '0);
    add_command(OP_UNUSED, -1);
    add_command(ssm_pkg::OP_PUSH_A, 7);
    add_command(ssm_pkg::OP_PUSH_B, -7);
    add_command(ssm_pkg::OP_MERGE, '0);

    add_sequence(ssm_pkg::LIST_DEPTH + 1, 0, 1'b1);
    add_sequence(3, ssm_pkg::LIST_DEPTH + 2, 1'b0);
    add_sequence(ssm_pkg::LIST_DEPTH, ssm_pkg::LIST_DEPTH, 1'b1);
    while (stim_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        na = $urandom_range(0, 4);
        nb = 0;
        if ($urandom_range(0, 1) == 0) begin
          nb = na;
          na = 0;
        end
      end else if (r < 12) begin
        na = $urandom_range(1, 4);
        nb = $urandom_range(20, ssm_pkg::LIST_DEPTH + 2);
        if ($urandom_range(0, 1) == 0) begin
          r = na;
          na = nb;
          nb = r;
        end
      end else begin
        na = $urandom_range(1, 6);
        nb = $urandom_range(1, 6);
      end
      add_sequence(na, nb, $urandom_range(0, 9) != 0);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d merges over %0d commands.",
             results_checked, merges_done, cmds_accepted);
    $display("Merge outcomes: %0d success, %0d unsorted, %0d empty, %0d overflow.",
             outcome_count[ssm_pkg::STATUS_SUCCESS], outcome_count[ssm_pkg::STATUS_UNSORTED],
             outcome_count[ssm_pkg::STATUS_EMPTY], outcome_count[ssm_pkg::STATUS_OVERFLOW]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb_sorted_sequence_merge passed");
    end else begin
      $display("tb_sorted_sequence_merge failed");
    end
    $finish;
  end

endmodule
